>>> design/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg: shared types and constants of the 3x3 matrix inverse core
// Request and response structs, divider lane type, widths and saturation codes.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  // Element and intermediate widths. These follow from the 32-bit elements
  // alone; the fraction position only moves the binary point.
  localparam int unsigned EW   = 32;  // element width
  localparam int unsigned CW   = 65;  // signed cofactor width
  localparam int unsigned MW   = 64;  // cofactor magnitude width
  localparam int unsigned DW   = 97;  // signed determinant width
  localparam int unsigned DMW  = 96;  // determinant magnitude width
  localparam int unsigned DENW = 97;  // divisor width (twice the magnitude)
  localparam int unsigned QW   = 32;  // quotient width

  // Accepting edge to the cycle in which the response is shown.
  localparam int unsigned LATENCY = 41;

  localparam logic [EW-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [EW-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [EW-1:0] a00;
    logic signed [EW-1:0] a01;
    logic signed [EW-1:0] a02;
    logic signed [EW-1:0] a10;
    logic signed [EW-1:0] a11;
    logic signed [EW-1:0] a12;
    logic signed [EW-1:0] a20;
    logic signed [EW-1:0] a21;
    logic signed [EW-1:0] a22;
  } m3inv_req_t;

  typedef struct packed {
    logic signed [EW-1:0] b00;
    logic signed [EW-1:0] b01;
    logic signed [EW-1:0] b02;
    logic signed [EW-1:0] b10;
    logic signed [EW-1:0] b11;
    logic signed [EW-1:0] b12;
    logic signed [EW-1:0] b20;
    logic signed [EW-1:0] b21;
    logic signed [EW-1:0] b22;
    logic                 invertible;
  } m3inv_rsp_t;

  // One lane of the bit-serial restoring divider pipeline.
  typedef struct packed {
    logic [DENW-1:0] rem;
    logic [QW-1:0]   quo;
    logic [QW-1:0]   nlo;
    logic            neg;
    logic            ovf;
  } div_lane_t;

endpackage

>>> design/matrix3x3_inverse_core.sv
// Throughput: one request per cycle; busy_o is never raised.
// The 32-stage restoring divider (one quotient bit per stage) sets the latency.
// Reset: rst_ni clears all valid bits asynchronously; payload is not reset.
// The receiver cannot stall, so the pipeline advances on every clock.
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core: pipelined 3x3 fixed-point matrix inverse
// Forms the nine cofactors and the determinant exactly, then divides each
// adjugate element by the determinant with rounding and saturation.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core #(
  parameter int unsigned FRAC_BITS = m3inv_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  m3inv_pkg::m3inv_req_t  req_i,
  output logic                   done_o,
  output m3inv_pkg::m3inv_rsp_t  rsp_o
);
  import m3inv_pkg::*;

  // The numerator |C| * 2^(2F+1) + |D| feeds the divider. Its width grows
  // with the fraction bits; the divisor width does not.
  localparam int unsigned SH   = 2 * FRAC_BITS + 1;
  localparam int unsigned NW   = ((MW + SH) > DMW ? (MW + SH) : DMW) + 1;
  localparam int unsigned HW   = NW - QW;
  localparam int unsigned CMPW = (HW > DENW) ? HW : DENW;

  // Element indices of the two products of each cofactor, row-major.
  localparam int unsigned COF_IDX [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // The pipeline never holds, so a request is taken whenever start_i is high.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  logic signed [EW-1:0] m [9];
  assign m[0] = req_i.a00;
  assign m[1] = req_i.a01;
  assign m[2] = req_i.a02;
  assign m[3] = req_i.a10;
  assign m[4] = req_i.a11;
  assign m[5] = req_i.a12;
  assign m[6] = req_i.a20;
  assign m[7] = req_i.a21;
  assign m[8] = req_i.a22;

  // Valid bits of stages one to seven.
  logic [6:0] vpre_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpre_q <= '0;
    end else begin
      vpre_q <= {vpre_q[5:0], accept};
    end
  end

  // Stage 1: the eighteen element products, each one 32x32 multiplier.
  logic signed [2*EW-1:0] pa_q [9];
  logic signed [2*EW-1:0] pb_q [9];
  logic signed [EW-1:0]   row1_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      pa_q[i] <= m[COF_IDX[i][0]] * m[COF_IDX[i][1]];
      pb_q[i] <= m[COF_IDX[i][2]] * m[COF_IDX[i][3]];
    end
    for (int j = 0; j < 3; j++) begin
      row1_q[j] <= m[j];
    end
  end

  // Stage 2: exact cofactors.
  logic signed [CW-1:0] cof2_q [9];
  logic signed [EW-1:0] row2_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      cof2_q[i] <= CW'(pa_q[i]) - CW'(pb_q[i]);
    end
    row2_q <= row1_q;
  end

  // Stage 3: first-row element times first-column cofactor, split into a
  // low and a high partial product so that no multiplier exceeds 32x33.
  logic signed [CW-1:0] plo3_q [3];
  logic signed [CW-1:0] phi3_q [3];
  logic signed [CW-1:0] cof3_q [9];
  logic signed [32:0]   c_lo [3];
  logic signed [32:0]   c_hi [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      c_lo[j] = $signed({1'b0, cof2_q[3*j][31:0]});
      c_hi[j] = $signed(cof2_q[3*j][CW-1:32]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      plo3_q[j] <= row2_q[j] * c_lo[j];
      phi3_q[j] <= row2_q[j] * c_hi[j];
    end
    cof3_q <= cof2_q;
  end

  // Stage 4: recombine the partial products.
  logic signed [DW-1:0] prd4_q [3];
  logic signed [CW-1:0] cof4_q [9];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      prd4_q[j] <= DW'(plo3_q[j]) + (DW'(phi3_q[j]) <<< 32);
    end
    cof4_q <= cof3_q;
  end

  // Stage 5: determinant along the first row.
  logic signed [DW-1:0] det5_q;
  logic signed [CW-1:0] cof5_q [9];

  always_ff @(posedge clk_i) begin
    det5_q <= prd4_q[0] + prd4_q[1] + prd4_q[2];
    cof5_q <= cof4_q;
  end

  // Stage 6: magnitudes and signs.
  logic [DMW-1:0] dmag6_q;
  logic           dneg6_q;
  logic           dzero6_q;
  logic [MW-1:0]  cmag6_q [9];
  logic           cneg6_q [9];
  logic [DW-1:0]  det_n;
  logic [CW-1:0]  cof_n [9];

  always_comb begin
    det_n = -det5_q;
    for (int i = 0; i < 9; i++) begin
      cof_n[i] = -cof5_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    dmag6_q  <= det5_q[DW-1] ? det_n[DMW-1:0] : det5_q[DMW-1:0];
    dneg6_q  <= det5_q[DW-1];
    dzero6_q <= (det5_q == '0);
    for (int i = 0; i < 9; i++) begin
      cmag6_q[i] <= cof5_q[i][CW-1] ? cof_n[i][MW-1:0] : cof5_q[i][MW-1:0];
      cneg6_q[i] <= cof5_q[i][CW-1];
    end
  end

  // Stage 7: rounding numerator and the doubled divisor. Dividing
  // |C| * 2^(2F+1) + |D| by 2|D| rounds half away from zero.
  logic [NW-1:0]   num7_q [9];
  logic            neg7_q [9];
  logic [DENW-1:0] den7_q;
  logic            inv7_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      num7_q[i] <= NW'({cmag6_q[i], {SH{1'b0}}}) + NW'(dmag6_q);
      neg7_q[i] <= cneg6_q[i] ^ dneg6_q;
    end
    den7_q <= {dmag6_q, 1'b0};
    inv7_q <= !dzero6_q;
  end

  // Divider pipeline. Entry 0 is loaded from stage 7; each later entry
  // resolves one quotient bit.
  logic            dv_q   [QW+1];
  logic [DENW-1:0] den_q  [QW+1];
  logic            inv_q  [QW+1];
  div_lane_t       lane_q [QW+1][9];

  logic [CMPW-1:0] hi_ext [9];
  logic [CMPW-1:0] den_ext;

  always_comb begin
    den_ext = CMPW'(den7_q);
    for (int i = 0; i < 9; i++) begin
      hi_ext[i] = CMPW'(num7_q[i][NW-1:QW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= vpre_q[6];
    end
  end

  // A quotient of 2^32 or more is flagged here; below that the upper
  // numerator bits are already smaller than the divisor.
  always_ff @(posedge clk_i) begin
    den_q[0] <= den7_q;
    inv_q[0] <= inv7_q;
    for (int i = 0; i < 9; i++) begin
      lane_q[0][i].ovf <= (hi_ext[i] >= den_ext);
      lane_q[0][i].rem <= hi_ext[i][DENW-1:0];
      lane_q[0][i].quo <= '0;
      lane_q[0][i].nlo <= num7_q[i][QW-1:0];
      lane_q[0][i].neg <= neg7_q[i];
    end
  end

  function automatic div_lane_t div_step(input div_lane_t l, input logic [DENW-1:0] den);
    logic [DENW:0] trial;
    logic [DENW:0] diff;
    div_lane_t     o;
    trial = {l.rem, l.nlo[QW-1]};
    diff  = trial - {1'b0, den};
    o     = l;
    o.nlo = {l.nlo[QW-2:0], 1'b0};
    if (trial >= {1'b0, den}) begin
      o.rem = diff[DENW-1:0];
      o.quo = {l.quo[QW-2:0], 1'b1};
    end else begin
      o.rem = trial[DENW-1:0];
      o.quo = {l.quo[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  for (genvar s = 0; s < QW; s++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s+1] <= 1'b0;
      end else begin
        dv_q[s+1] <= dv_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[s+1] <= den_q[s];
      inv_q[s+1] <= inv_q[s];
      for (int i = 0; i < 9; i++) begin
        lane_q[s+1][i] <= div_step(lane_q[s][i], den_q[s]);
      end
    end
  end

  // Output stage: saturate, apply the sign, and clear a singular result.
  logic [EW-1:0] b [9];
  div_lane_t     fl;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      fl = lane_q[QW][i];
      if (!fl.neg) begin
        b[i] = (fl.ovf || (fl.quo > SAT_POS)) ? SAT_POS : fl.quo;
      end else begin
        b[i] = (fl.ovf || (fl.quo > SAT_NEG)) ? SAT_NEG : (-fl.quo);
      end
      if (!inv_q[QW]) begin
        b[i] = '0;
      end
    end
  end

  m3inv_rsp_t rsp_d, rsp_q;
  logic       done_q;

  always_comb begin
    rsp_d.b00        = b[0];
    rsp_d.b01        = b[1];
    rsp_d.b02        = b[2];
    rsp_d.b10        = b[3];
    rsp_d.b11        = b[4];
    rsp_d.b12        = b[5];
    rsp_d.b20        = b[6];
    rsp_d.b21        = b[7];
    rsp_d.b22        = b[8];
    rsp_d.invertible = inv_q[QW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> design/m3inv_checker.sv
// ----------------------------------------------------------------------------
// m3inv_checker: port-level checks of the 3x3 matrix inverse core
// Checks fixed latency, no response without a request, and singular responses.
// ----------------------------------------------------------------------------
module m3inv_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input m3inv_pkg::m3inv_req_t req_i,
  input logic                  done_o,
  input m3inv_pkg::m3inv_rsp_t rsp_o
);
  import m3inv_pkg::*;

  logic req_taken;
  assign req_taken = start_i && !busy_o;

  // Every accepted request comes back after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_taken |-> ##LATENCY done_o)
    else $error("response missing after accepted request");

  // No response appears without a request the fixed latency earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req_taken, LATENCY))
    else $error("response without matching request");

  // A singular response carries an all-zero matrix.
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.invertible) |->
      (rsp_o.b00 == '0 && rsp_o.b01 == '0 && rsp_o.b02 == '0 &&
       rsp_o.b10 == '0 && rsp_o.b11 == '0 && rsp_o.b12 == '0 &&
       rsp_o.b20 == '0 && rsp_o.b21 == '0 && rsp_o.b22 == '0))
    else $error("singular response with nonzero elements");

  // An all-zero request is singular.
  a_zero_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_taken && req_i == '0) |-> ##LATENCY (done_o && !rsp_o.invertible))
    else $error("zero matrix reported invertible");

endmodule

bind matrix3x3_inverse_core m3inv_checker u_m3inv_checker (.*);
